FILE: design/nsr_pkg.sv
// Shared types and constants for the NMEA sentence receiver.
`timescale 1ns / 1ps
`default_nettype none

package nsr_pkg;

    localparam int IDX_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int FIELD_W  = 6;
    localparam int IN_DW    = 24;
    localparam int OUT_DW   = 32;

    // A line must hold more than this many bytes to be kept.
    localparam logic [IDX_W-1:0] MIN_LEN = 7'd8;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_FIND  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RX_WAIT    = 2'd0,
        RX_COLLECT = 2'd1,
        RX_READY   = 2'd2
    } rx_status_t;

endpackage

`default_nettype wire

FILE: design/nsr_line_ram.sv
// Line buffer RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module nsr_line_ram #(
    parameter int DEPTH = 79,
    parameter int AW    = 7
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/nmea_sentence_receiver.sv
// Top level of the NMEA sentence receiver: framer, field scanner and result register.
//
// Usage:
//   One command beat enters on s_axis: s_axis_tuser carries the opcode (push byte,
//   find field, read stored byte, clear line), s_axis_tdata the operands.
//   Every command gives exactly one result beat on m_axis: status, ready line
//   length, field start/length and the read byte in m_axis_tdata, the
//   field-found flag in m_axis_tuser.
//   Push, read and clear: the accepted command moves to S_DONE, which loads the
//   result beat once the output register is free, and the next command can then be taken.
//   Find walks the stored line through the RAM read port one byte per cycle in
//   S_SCAN before S_DONE; it stops early at the closing delimiter of the
//   requested field, or at a star reached before that field.
//   s_axis_tready is high only while no command is in flight. A finished result
//   sits in the output register until taken; while m_axis_tready is low the block
//   still takes one more command and works it, then holds that result and keeps
//   s_axis_tready low until the output register frees.
//   Reset returns the framer to waiting for a start byte and empties the
//   output register; no clearing pass runs, the line RAM is overwritten as
//   bytes arrive.
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_receiver #(
    parameter int LINE_MAX = 79
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] data_byte, [13:8] field_number, [20:14] char_index, [23:21] zero
    input  wire logic [nsr_pkg::IN_DW-1:0]   s_axis_tdata,
    // [1:0] opcode
    input  wire logic [1:0]                  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [1:0] rx_status, [8:2] line_length, [15:9] start_index,
    // [22:16] field_length, [30:23] char_out, [31] zero
    output logic [nsr_pkg::OUT_DW-1:0]       m_axis_tdata,
    // [0] field_found
    output logic                             m_axis_tuser
);

    import nsr_pkg::*;

    localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam logic [IDX_W-1:0] LINE_LIMIT = IDX_W'(LINE_MAX);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } seq_t;

    seq_t                state_reg;
    rx_status_t          framer_reg;
    logic [IDX_W-1:0]    write_index_reg;
    logic [IDX_W-1:0]    ready_length_reg;
    logic [BYTE_W-1:0]   tail0_reg, tail1_reg, tail2_reg;
    op_t                 op_reg;
    logic                read_ok_reg;
    logic [FIELD_W-1:0]  number_reg;
    logic [IDX_W-1:0]    issue_idx_reg;
    logic [IDX_W-1:0]    eval_idx_reg;
    logic [IDX_W-1:0]    delims_reg;
    logic                have_start_reg;
    logic [IDX_W-1:0]    first_reg;
    logic                res_found_reg;
    logic [IDX_W-1:0]    res_start_reg;
    logic [IDX_W-1:0]    res_len_reg;
    logic                m_valid_reg;
    logic [OUT_DW-1:0]   m_data_reg;
    logic                m_user_reg;

    // Command decode
    logic                accept;
    op_t                 in_op;
    logic [BYTE_W-1:0]   in_byte;
    logic [FIELD_W-1:0]  in_number;
    logic [IDX_W-1:0]    in_index;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_op         = op_t'(s_axis_tuser);
    assign in_byte       = s_axis_tdata[7:0];
    assign in_number     = s_axis_tdata[13:8];
    assign in_index      = s_axis_tdata[20:14];

    // Push path
    logic                ovf;
    rx_status_t          eff_framer;
    logic [IDX_W-1:0]    eff_idx;
    logic                is_eol;
    logic                line_ok;
    rx_status_t          push_framer_next;
    logic [IDX_W-1:0]    push_idx_next;
    logic [IDX_W-1:0]    push_len_next;
    logic                push_store;
    logic [IDX_W-1:0]    push_addr;

    assign ovf        = (write_index_reg >= LINE_LIMIT);
    assign eff_framer = ovf ? RX_WAIT : framer_reg;
    assign eff_idx    = ovf ? '0 : write_index_reg;
    assign is_eol     = (in_byte == CH_CR) || (in_byte == CH_LF);
    // tail2 holds the byte three back from the write position
    assign line_ok    = (eff_idx > MIN_LEN) && (tail2_reg == CH_STAR);

    always_comb
    begin
        push_framer_next = framer_reg;
        push_idx_next    = write_index_reg;
        push_len_next    = ready_length_reg;
        push_store       = 1'b0;
        push_addr        = eff_idx;
        unique case (eff_framer)
            RX_WAIT:
            begin
                push_len_next = '0;
                if (in_byte == CH_DOLLAR)
                begin
                    push_store       = 1'b1;
                    push_addr        = '0;
                    push_idx_next    = 7'd1;
                    push_framer_next = RX_COLLECT;
                end
                else
                begin
                    push_idx_next    = '0;
                    push_framer_next = RX_WAIT;
                end
            end
            RX_COLLECT:
            begin
                if (is_eol)
                begin
                    push_idx_next = '0;
                    if (line_ok)
                    begin
                        push_len_next    = eff_idx;
                        push_framer_next = RX_READY;
                    end
                    else
                    begin
                        push_len_next    = '0;
                        push_framer_next = RX_WAIT;
                    end
                end
                else
                begin
                    push_store    = 1'b1;
                    push_idx_next = eff_idx + 7'd1;
                end
            end
            RX_READY:
            begin
                // ignore bytes until the line is cleared
            end
            default:
            begin
                push_framer_next = RX_WAIT;
                push_idx_next    = '0;
                push_len_next    = '0;
            end
        endcase
    end

    // Field scan evaluation on the byte returned by the RAM
    logic [BYTE_W-1:0]   rd_data;
    logic                sc_comma, sc_star;
    logic [IDX_W-1:0]    sc_delims;
    logic [IDX_W-1:0]    sc_number;
    logic                sc_fail, sc_open, sc_hit, sc_last;

    assign sc_comma  = (rd_data == CH_COMMA);
    assign sc_star   = (rd_data == CH_STAR);
    assign sc_delims = delims_reg + 7'd1;
    assign sc_number = IDX_W'(number_reg);
    assign sc_fail   = sc_star && (sc_delims <= sc_number);
    assign sc_open   = sc_comma && (sc_delims == sc_number);
    assign sc_hit    = (sc_comma || sc_star) && (sc_delims == sc_number + 7'd1);
    assign sc_last   = (eval_idx_reg == ready_length_reg - 7'd1);

    // RAM ports
    logic                read_ok;
    logic                have_line;
    logic                wr_en;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_idx;

    assign have_line = (framer_reg == RX_READY);
    assign read_ok   = have_line && (in_index < ready_length_reg);
    assign wr_en     = accept && (in_op == OP_PUSH) && push_store;

    always_comb
    begin
        rd_en  = 1'b0;
        rd_idx = issue_idx_reg;
        if (accept && (in_op == OP_READ))
        begin
            rd_en  = read_ok;
            rd_idx = in_index;
        end
        else if (accept && (in_op == OP_FIND))
        begin
            rd_en  = have_line;
            rd_idx = '0;
        end
        else if (state_reg == S_SCAN)
        begin
            rd_en  = (issue_idx_reg < ready_length_reg);
        end
    end

    nsr_line_ram #(
        .DEPTH (LINE_MAX),
        .AW    (AW)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (push_addr[AW-1:0]),
        .wr_data (in_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (rd_data)
    );

    logic out_free;
    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            framer_reg       <= RX_WAIT;
            write_index_reg  <= '0;
            ready_length_reg <= '0;
            tail0_reg        <= '0;
            tail1_reg        <= '0;
            tail2_reg        <= '0;
            op_reg           <= OP_PUSH;
            read_ok_reg      <= 1'b0;
            number_reg       <= '0;
            issue_idx_reg    <= '0;
            eval_idx_reg     <= '0;
            delims_reg       <= '0;
            have_start_reg   <= 1'b0;
            first_reg        <= '0;
            res_found_reg    <= 1'b0;
            res_start_reg    <= '0;
            res_len_reg      <= '0;
            m_valid_reg      <= 1'b0;
            m_data_reg       <= '0;
            m_user_reg       <= 1'b0;
        end
        else
        begin
            // S_DONE reloads the output register itself when it frees
            if (m_valid_reg && m_axis_tready && (state_reg != S_DONE))
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg        <= in_op;
                        read_ok_reg   <= read_ok;
                        number_reg    <= in_number;
                        res_found_reg <= 1'b0;
                        res_start_reg <= '0;
                        res_len_reg   <= '0;
                        state_reg     <= S_DONE;
                        unique case (in_op)
                            OP_PUSH:
                            begin
                                framer_reg       <= push_framer_next;
                                write_index_reg  <= push_idx_next;
                                ready_length_reg <= push_len_next;
                                if (push_store)
                                begin
                                    tail0_reg <= in_byte;
                                    tail1_reg <= tail0_reg;
                                    tail2_reg <= tail1_reg;
                                end
                            end
                            OP_FIND:
                            begin
                                issue_idx_reg  <= 7'd1;
                                eval_idx_reg   <= '0;
                                delims_reg     <= '0;
                                have_start_reg <= 1'b0;
                                first_reg      <= '0;
                                if (have_line)
                                begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            OP_READ:
                            begin
                            end
                            OP_CLEAR:
                            begin
                                framer_reg       <= RX_WAIT;
                                write_index_reg  <= '0;
                                ready_length_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    issue_idx_reg <= issue_idx_reg + 7'd1;
                    eval_idx_reg  <= issue_idx_reg;
                    if (sc_comma || sc_star)
                    begin
                        delims_reg <= sc_delims;
                    end
                    if (sc_open)
                    begin
                        have_start_reg <= 1'b1;
                        first_reg      <= eval_idx_reg + 7'd1;
                    end
                    priority if (sc_fail)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (sc_hit)
                    begin
                        state_reg <= S_DONE;
                        if (have_start_reg)
                        begin
                            res_found_reg <= 1'b1;
                            res_start_reg <= first_reg;
                            res_len_reg   <= eval_idx_reg - first_reg;
                        end
                    end
                    else if (sc_last)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= res_found_reg;
                        m_data_reg  <= {
                            1'b0,
                            ((op_reg == OP_READ) && read_ok_reg) ? rd_data : 8'h00,
                            res_len_reg,
                            res_start_reg,
                            have_line ? ready_length_reg : 7'd0,
                            framer_reg
                        };
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

`default_nettype wire

FILE: design/nsr_checker.sv
// Port-level checks for the NMEA sentence receiver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module nsr_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    input  wire logic [nsr_pkg::OUT_DW-1:0] m_axis_tdata,
    input  wire logic                       m_axis_tuser
);

    import nsr_pkg::*;

    // hold a result beat until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != RX_READY) |-> (m_axis_tdata[8:2] == 7'd0))
        else $error("line length reported without a ready line");

    a_found_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[1:0] == RX_READY))
        else $error("field found without a ready line");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[22:9] == 14'd0))
        else $error("field position reported for a missing field");

    a_ready_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == RX_READY) |-> (m_axis_tdata[8:2] > MIN_LEN))
        else $error("ready line shorter than the minimum");

endmodule

bind nmea_sentence_receiver nsr_checker u_nsr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: tb/sv/nmea_sentence_receiver_test.sv
// Self-checking bench for the NMEA sentence receiver: command beats in, predicted replies checked out.
`timescale 1ns / 1ps

module nmea_sentence_receiver_test;
    import nsr_pkg::*;

    localparam int LINE_MAX     = 79;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = LINE_MAX + 8;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 260;

    typedef enum {
        SENT_GOOD,
        SENT_NO_STAR,
        SENT_EARLY_END
    } sentence_form_t;

    typedef struct {
        op_t        op;
        logic [7:0] data;
        logic [5:0] fnum;
        logic [6:0] cidx;
    } rx_cmd_t;

    typedef struct {
        rx_status_t status;
        logic [6:0] length;
        logic       found;
        logic [6:0] fstart;
        logic [6:0] flen;
        logic [7:0] ch;
    } rx_reply_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    wire               s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata = '0;
    logic [1:0]        s_axis_tuser = '0;
    wire               m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    wire [OUT_DW-1:0]  m_axis_tdata;
    wire               m_axis_tuser;

    // Predicted framer state
    logic [7:0] line_bytes [LINE_MAX];
    int         fill_count = 0;
    rx_status_t framer = RX_WAIT;
    int         held_length = 0;

    rx_reply_t replies_due[$];
    int        mismatches = 0;
    int        counted_items = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        cycle_count = 0;
    int        hold_count = 0;
    logic      long_hold = 1'b0;

    nmea_sentence_receiver #(
        .LINE_MAX(LINE_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic void drop_line();
        fill_count = 0;
        framer = RX_WAIT;
        held_length = 0;
    endfunction

    function automatic void push_into_line(logic [7:0] b);
        if (fill_count >= LINE_MAX)
            drop_line();
        if (framer == RX_WAIT)
        begin
            if (b == CH_DOLLAR)
            begin
                line_bytes[0] = b;
                fill_count = 1;
                framer = RX_COLLECT;
            end
        end
        else if (framer == RX_COLLECT)
        begin
            if (b == CH_CR || b == CH_LF)
            begin
                if (fill_count > MIN_LEN && line_bytes[fill_count - 3] == CH_STAR)
                begin
                    held_length = fill_count;
                    fill_count = 0;
                    framer = RX_READY;
                end
                else
                    drop_line();
            end
            else
            begin
                line_bytes[fill_count] = b;
                fill_count++;
            end
        end
    endfunction

    // Walk the held line counting delimiters; a star ends the search early.
    function automatic bit scan_for_field(int number, output int first, output int span);
        int         delims;
        int         i;
        bit         have_start;
        logic [7:0] c;
        delims = 0;
        have_start = 0;
        first = 0;
        span = 0;
        if (framer != RX_READY)
            return 0;
        for (i = 0; i < held_length && i < LINE_MAX; i++)
        begin
            c = line_bytes[i];
            if (c != CH_COMMA && c != CH_STAR)
                continue;
            delims++;
            if (c == CH_STAR && delims <= number)
                return 0;
            if (delims == number && c == CH_COMMA)
            begin
                have_start = 1;
                first = i + 1;
            end
            if (delims == number + 1)
            begin
                if (!have_start)
                    return 0;
                span = i - first;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic rx_reply_t receiver_reply(rx_cmd_t c);
        rx_reply_t r;
        int        first;
        int        span;
        r.status = RX_WAIT;
        r.length = '0;
        r.found = 1'b0;
        r.fstart = '0;
        r.flen = '0;
        r.ch = '0;
        case (c.op)
            OP_PUSH:  push_into_line(c.data);
            OP_FIND:
            begin
                if (scan_for_field(c.fnum, first, span))
                begin
                    r.found = 1'b1;
                    r.fstart = 7'(first);
                    r.flen = 7'(span);
                end
            end
            OP_READ:
            begin
                if (framer == RX_READY && c.cidx < held_length)
                    r.ch = line_bytes[c.cidx];
            end
            OP_CLEAR: drop_line();
        endcase
        r.status = framer;
        r.length = (framer == RX_READY) ? 7'(held_length) : 7'd0;
        return r;
    endfunction

    function automatic rx_cmd_t rand_cmd(op_t op);
        rx_cmd_t c;
        c.op = op;
        c.data = 8'($urandom_range(0, 255));
        c.fnum = 6'($urandom_range(0, 63));
        c.cidx = 7'($urandom_range(0, 127));
        return c;
    endfunction

    function automatic logic [7:0] any_text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    function automatic logic [7:0] body_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 18)
            return CH_COMMA;
        if (r < 21)
            return CH_STAR;
        if (r < 24)
            return any_text_byte();
        return 8'($urandom_range(8'h30, 8'h5A));
    endfunction

    function automatic logic [7:0] hex_char();
        string digits;
        digits = "0123456789ABCDEF";
        return digits[$urandom_range(0, 15)];
    endfunction

    // Valid stays high across back-to-back beats; drop it only on an idle cycle.
    task automatic send_cmd(rx_cmd_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, c.cidx, c.fnum, c.data};
        s_axis_tuser <= c.op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        counted_items++;
        replies_due.push_back(receiver_reply(c));
    endtask

    task automatic send_push(logic [7:0] b);
        rx_cmd_t c;
        c = rand_cmd(OP_PUSH);
        c.data = b;
        send_cmd(c);
    endtask

    task automatic send_find(int number);
        rx_cmd_t c;
        c = rand_cmd(OP_FIND);
        c.fnum = 6'(number);
        send_cmd(c);
    endtask

    task automatic send_read(int index);
        rx_cmd_t c;
        c = rand_cmd(OP_READ);
        c.cidx = 7'(index);
        send_cmd(c);
    endtask

    task automatic send_clear();
        send_cmd(rand_cmd(OP_CLEAR));
    endtask

    task automatic send_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_push(s[i]);
    endtask

    task automatic send_sentence(int body_len, sentence_form_t form);
        logic [7:0] line_q[$];
        int         i;
        line_q.push_back(CH_DOLLAR);
        for (i = 0; i < body_len; i++)
            line_q.push_back(body_char());
        if (form == SENT_NO_STAR)
            line_q.push_back(8'($urandom_range(8'h30, 8'h5A)));
        else
            line_q.push_back(CH_STAR);
        line_q.push_back(hex_char());
        line_q.push_back(hex_char());
        if (form == SENT_EARLY_END)
            line_q = line_q[0:$urandom_range(0, line_q.size() - 2)];
        line_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        foreach (line_q[k])
            send_push(line_q[k]);
    endtask

    task automatic query_ready_line(int count);
        int r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_find($urandom_range(0, 99) < 80 ? $urandom_range(0, 16)
                                                     : $urandom_range(0, 63));
            else if (r < 85)
                send_read($urandom_range(0, 99) < 80 ? $urandom_range(0, held_length + 2)
                                                     : $urandom_range(0, 127));
            else
                send_push(8'($urandom_range(0, 255)));
        end
    endtask

    // Two over-long lines also write every entry of the line store.
    task automatic test_overflow();
        send_push(CH_DOLLAR);
        repeat (LINE_MAX - 1)
            send_push(any_text_byte());
        send_push(CH_CR);
        send_push(CH_DOLLAR);
        repeat (LINE_MAX - 1)
            send_push(any_text_byte());
        send_push(CH_DOLLAR);
        send_read(0);
        send_clear();
    endtask

    task automatic test_idle_queries();
        send_read(0);
        send_read(127);
        send_find(1);
        send_push(CH_LF);
        send_push(CH_CR);
        send_push(8'h00);
        send_push(8'hFF);
        send_clear();
        send_push(CH_DOLLAR);
        send_find(1);
        send_read(0);
        send_clear();
        send_clear();
    endtask

    task automatic test_field_lookup();
        send_text("$GP,A,,B*5C");
        send_push(CH_CR);
        send_find(0);
        send_find(1);
        send_find(2);
        send_find(3);
        send_find(4);
        send_find(63);
        send_read(0);
        send_read(10);
        send_read(11);
        send_read(127);
        send_push(CH_DOLLAR);
        send_push(8'hFF);
        send_read(0);
        send_clear();
        send_read(0);
    endtask

    task automatic test_line_limits();
        send_text("$ABCDE*12");
        send_push(CH_LF);
        send_find(1);
        send_clear();
        send_text("$ABCD*12");
        send_push(CH_CR);
        send_text("$ABC,DEF12");
        send_push(CH_CR);
        send_text("$A,B,C*,1");
        send_push(CH_CR);
        send_find(2);
        send_find(3);
        send_clear();
        // longest line that still fits
        send_sentence(LINE_MAX - 5, SENT_GOOD);
        send_read(LINE_MAX - 2);
        send_find(1);
        send_clear();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold <= 1'b1;
        send_sentence(12, SENT_GOOD);
        query_ready_line(6);
        send_clear();
        while (long_hold)
            @(posedge clk);
    endtask

    task automatic random_traffic(int target);
        int pick;
        int body_len;
        counted_items = 0;
        while (counted_items < target)
        begin
            pick = $urandom_range(0, 99);
            body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, LINE_MAX - 4)
                                                   : $urandom_range(4, 30);
            if (pick < 60)
            begin
                send_sentence(body_len, SENT_GOOD);
                query_ready_line($urandom_range(2, 8));
                send_clear();
            end
            else if (pick < 70)
                send_sentence(body_len, $urandom_range(0, 1) ? SENT_NO_STAR : SENT_EARLY_END);
            else if (pick < 78)
                repeat ($urandom_range(1, 6))
                    send_push(8'($urandom_range(0, 255)));
            else if (pick < 90)
                repeat ($urandom_range(1, 4))
                    send_cmd(rand_cmd(op_t'($urandom_range(0, 3))));
            else if (pick < 95)
                send_sentence($urandom_range(LINE_MAX - 3, LINE_MAX + 11), SENT_GOOD);
            else
            begin
                send_push(CH_DOLLAR);
                repeat ($urandom_range(0, 10))
                    send_push(body_char());
                send_clear();
            end
        end
    endtask

    task automatic test_random_phases();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_traffic(RANDOM_ITEMS / 4);
        send_idle_pct = 51;
        recv_stall_pct = 0;
        random_traffic(RANDOM_ITEMS / 4);
        send_idle_pct = 0;
        recv_stall_pct = 51;
        random_traffic(RANDOM_ITEMS / 4);
        send_idle_pct = 7;
        recv_stall_pct = 7;
        random_traffic(RANDOM_ITEMS / 4);
    endtask

    // Receiver side: random stalls, or a long hold-off counted here.
    always @(posedge clk)
    begin
        if (long_hold)
        begin
            m_axis_tready <= 1'b0;
            hold_count = hold_count + 1;
            if (hold_count >= LONG_HOLD)
            begin
                hold_count = 0;
                long_hold <= 1'b0;
            end
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        rx_reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (replies_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: reply beat with none expected, expected nothing got %h/%b",
                         $time, m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = replies_due.pop_front();
                check_field("rx_status", want.status, m_axis_tdata[1:0]);
                check_field("line_length", want.length, m_axis_tdata[8:2]);
                check_field("start_index", want.fstart, m_axis_tdata[15:9]);
                check_field("field_length", want.flen, m_axis_tdata[22:16]);
                check_field("char_out", want.ch, m_axis_tdata[30:23]);
                check_field("field_found", want.found, m_axis_tuser);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_overflow();
        test_idle_queries();
        test_field_lookup();
        test_line_limits();
        test_backpressure();
        test_random_phases();
        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
